### rtl/core/smh_pkg.sv
// Shared types and constants of the sixteen-ary min-heap priority queue.
`default_nettype none

package smh_pkg;

  // One signed heap key.
  typedef logic signed [31:0] key_t;

  // Value that a free heap slot holds.
  localparam key_t KEY_FREE = 32'sh7FFF_FFFF;

  // Width and reset value of the capacity register.
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Operation codes of an input transaction.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRD  = 8'b0000_0010,
    S_PCMP = 8'b0000_0100,
    S_SRD  = 8'b0000_1000,
    S_DESC = 8'b0001_0000,
    S_MIN1 = 8'b0010_0000,
    S_MIN2 = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

### rtl/core/smh_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module smh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/sixteen_ary_min_heap.sv
// Top level of the ARITY-ary min-heap priority queue with a row-organised key store.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   cfg     | in        | cfg_valid_i/ready_o   | cfg_data_i (capacity)
//   in      | in        | in_valid_i/ready_o    | command_i, key_i
//   out     | out       | out_valid_o/ready_i   | status_o, popped_key_o
//
// The root key lives in a register; key j >= 1 lives in RAM row (j-1)/ARITY, lane (j-1)%ARITY,
// so all children of node i sit in row i and one RAM read fetches them together.
// A push climbs the heap one level per pass, with one RAM read and one RAM write per level.
// A pop walks down one level per pass: read children, two-stage minimum, write back.
// At 1024 keys and ARITY 16 a walk spans at most three levels. One item is in flight at a time.
// Reset is asynchronous; RAM contents above the key count are never used, so no clearing pass.
// A result waiting on out_ready_i holds the sequencer in its final state.
`default_nettype none

module sixteen_ary_min_heap #(
  parameter int MAX_KEYS = 1024,
  parameter int ARITY    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [smh_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic signed [31:0]          key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          popped_key_o
);

  localparam int NW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int LW    = $clog2(ARITY);
  localparam int NV    = $clog2(ARITY + 1);
  localparam int ROWS  = (MAX_KEYS + ARITY - 2) / ARITY;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int G     = (ARITY + 3) / 4;
  localparam int DIV_SH = NW + LW;
  localparam int PW    = 2 * NW + 2;
  localparam int DIV_M = ((1 << DIV_SH) + ARITY - 1) / ARITY;
  localparam logic [PW-1:0] DIV_M_V  = PW'(DIV_M);
  localparam logic [NW-1:0] ARITY_NW = NW'(ARITY);

  typedef smh_pkg::key_t [ARITY-1:0] row_t;

  smh_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [smh_pkg::CAP_W-1:0] cap_q, cap_d;
  smh_pkg::key_t    root_q, root_d;
  smh_pkg::key_t    key_q, key_d;
  row_t             cur_row_q, cur_row_d;
  logic [RW-1:0]    par_row_q, par_row_d;
  logic [NW-1:0]    par_m1_q, par_m1_d;
  logic [RW-1:0]    pos_row_q, pos_row_d;
  logic [LW-1:0]    pos_lane_q, pos_lane_d;
  logic [NW-1:0]    pos_node_q, pos_node_d;
  logic             pos_root_q, pos_root_d;
  logic [NV-1:0]    nvalid_q, nvalid_d;
  smh_pkg::key_t    grp_val_q [G];
  logic [LW-1:0]    grp_idx_q [G];
  smh_pkg::key_t    grp_val_c [G];
  logic [LW-1:0]    grp_idx_c [G];
  smh_pkg::status_e res_status_q, res_status_d;
  smh_pkg::key_t    res_key_q, res_key_d;
  logic             out_valid_q, out_valid_d;
  smh_pkg::status_e out_status_q, out_status_d;
  smh_pkg::key_t    out_key_q, out_key_d;

  logic [NW-1:0]    div_arg;
  logic [PW-1:0]    div_prod;
  logic [RW-1:0]    div_q;
  logic [NW-1:0]    par_base;
  logic [LW-1:0]    par_lane;
  smh_pkg::key_t    par_val;
  row_t             lane_val;
  smh_pkg::key_t    best_val;
  logic [LW-1:0]    best_k;
  logic [31:0]      fst;
  logic [31:0]      rem;
  logic             full;
  logic             pos_wr;
  smh_pkg::key_t    pos_val;
  row_t             wr_row;

  logic             ram_we;
  logic [RW-1:0]    ram_waddr;
  logic             ram_re;
  logic [RW-1:0]    ram_raddr;
  row_t             ram_rdata;

  // Key store: one row holds the ARITY children of one node.
  smh_ram #(
    .WIDTH (ARITY * 32),
    .DEPTH (ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_row),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Division by ARITY through a reciprocal multiplication, exact for every node index.
  assign div_prod = PW'(div_arg) * DIV_M_V;
  assign div_q    = div_prod[DIV_SH +: RW];

  // Lane of the parent slot, taken from its registered row and index.
  assign par_base = NW'(par_row_q) * ARITY_NW;
  assign par_lane = LW'(par_m1_q - par_base);
  assign par_val  = (pos_row_q == '0) ? root_q : ram_rdata[par_lane];

  // A push is refused at the configured capacity or at the store depth.
  assign full = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= MAX_KEYS);

  // First child index of the sinking node and number of keys from that child on.
  assign fst = 32'(pos_node_q) * 32'(ARITY) + 32'd1;
  assign rem = 32'(count_q) - fst;

  // Children beyond the last key read as free slots.
  always_comb begin
    for (int k = 0; k < ARITY; k++) begin
      lane_val[k] = (NV'(k) < nvalid_q) ? ram_rdata[k] : smh_pkg::KEY_FREE;
    end
  end

  // First minimum stage: one winner per group of four lanes, lower lane wins a tie.
  always_comb begin
    for (int g = 0; g < G; g++) begin
      grp_val_c[g] = smh_pkg::KEY_FREE;
      grp_idx_c[g] = LW'(g * 4);
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < ARITY) begin
          if ((j == 0) || (lane_val[g * 4 + j] < grp_val_c[g])) begin
            grp_val_c[g] = lane_val[g * 4 + j];
            grp_idx_c[g] = LW'(g * 4 + j);
          end
        end
      end
    end
  end

  // Second minimum stage over the registered group winners.
  always_comb begin
    best_val = grp_val_q[0];
    best_k   = grp_idx_q[0];
    for (int g = 1; g < G; g++) begin
      if (grp_val_q[g] < best_val) begin
        best_val = grp_val_q[g];
        best_k   = grp_idx_q[g];
      end
    end
  end

  // Sequencer: push sift-up and pop sink, one heap level per pass.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cap_d        = cap_q;
    root_d       = root_q;
    key_d        = key_q;
    cur_row_d    = cur_row_q;
    par_row_d    = par_row_q;
    par_m1_d     = par_m1_q;
    pos_row_d    = pos_row_q;
    pos_lane_d   = pos_lane_q;
    pos_node_d   = pos_node_q;
    pos_root_d   = pos_root_q;
    nvalid_d     = nvalid_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    div_arg      = '0;
    ram_re       = 1'b0;
    ram_raddr    = div_q;
    pos_wr       = 1'b0;
    pos_val      = smh_pkg::KEY_FREE;

    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      smh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          key_d        = key_i;
          res_key_d    = '0;
          res_status_d = smh_pkg::STATUS_OK;
          if (command_i == smh_pkg::CMD_PUSH) begin
            if (full) begin
              res_status_d = smh_pkg::STATUS_FULL;
              state_d      = smh_pkg::S_FIN;
            end else if (count_q == '0) begin
              root_d  = key_i;
              count_d = count_q + CW'(1);
              state_d = smh_pkg::S_FIN;
            end else begin
              // Fetch the row that holds the new slot.
              div_arg   = NW'(count_q - CW'(1));
              ram_re    = 1'b1;
              par_row_d = div_q;
              par_m1_d  = div_arg;
              count_d   = count_q + CW'(1);
              state_d   = smh_pkg::S_PRD;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = smh_pkg::STATUS_EMPTY;
              state_d      = smh_pkg::S_FIN;
            end else begin
              res_key_d = root_q;
              count_d   = count_q - CW'(1);
              if (count_q == CW'(1)) begin
                root_d  = smh_pkg::KEY_FREE;
                state_d = smh_pkg::S_FIN;
              end else begin
                // Fetch the row that holds the last key.
                div_arg   = NW'(count_q - CW'(2));
                ram_re    = 1'b1;
                par_row_d = div_q;
                par_m1_d  = div_arg;
                state_d   = smh_pkg::S_SRD;
              end
            end
          end
        end
      end

      smh_pkg::S_PRD: begin
        // The new slot's row is in; fetch the row of its parent unless that is the root.
        cur_row_d  = ram_rdata;
        pos_row_d  = par_row_q;
        pos_lane_d = par_lane;
        pos_root_d = 1'b0;
        if (par_row_q != '0) begin
          div_arg   = NW'(par_row_q) - NW'(1);
          ram_re    = 1'b1;
          par_row_d = div_q;
          par_m1_d  = div_arg;
        end
        state_d = smh_pkg::S_PCMP;
      end

      smh_pkg::S_PCMP: begin
        pos_wr = 1'b1;
        if (par_val <= key_q) begin
          pos_val = key_q;
          state_d = smh_pkg::S_FIN;
        end else begin
          // Move the parent down and climb one level.
          pos_val = par_val;
          if (pos_row_q == '0) begin
            root_d  = key_q;
            state_d = smh_pkg::S_FIN;
          end else begin
            cur_row_d  = ram_rdata;
            pos_row_d  = par_row_q;
            pos_lane_d = par_lane;
            if (par_row_q != '0) begin
              div_arg   = NW'(par_row_q) - NW'(1);
              ram_re    = 1'b1;
              par_row_d = div_q;
              par_m1_d  = div_arg;
            end
          end
        end
      end

      smh_pkg::S_SRD: begin
        // Take the last key as the one to sink from the root.
        key_d      = ram_rdata[par_lane];
        pos_root_d = 1'b1;
        pos_node_d = '0;
        state_d    = smh_pkg::S_DESC;
      end

      smh_pkg::S_DESC: begin
        if (fst < 32'(count_q)) begin
          nvalid_d  = (rem >= 32'(ARITY)) ? NV'(ARITY) : NV'(rem);
          ram_re    = 1'b1;
          ram_raddr = RW'(pos_node_q);
          state_d   = smh_pkg::S_MIN1;
        end else begin
          pos_wr  = 1'b1;
          pos_val = key_q;
          state_d = smh_pkg::S_FIN;
        end
      end

      smh_pkg::S_MIN1: begin
        state_d = smh_pkg::S_MIN2;
      end

      smh_pkg::S_MIN2: begin
        pos_wr = 1'b1;
        if (key_q <= best_val) begin
          pos_val = key_q;
          state_d = smh_pkg::S_FIN;
        end else begin
          // Lift the smallest child and descend into its slot.
          pos_val    = best_val;
          cur_row_d  = ram_rdata;
          pos_row_d  = RW'(pos_node_q);
          pos_lane_d = best_k;
          pos_node_d = NW'(32'(pos_node_q) * 32'(ARITY) + 32'd1 + 32'(best_k));
          pos_root_d = 1'b0;
          state_d    = smh_pkg::S_DESC;
        end
      end

      smh_pkg::S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = res_key_q;
          state_d      = smh_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = smh_pkg::S_IDLE;
      end
    endcase

    // Writing the current slot goes to the root register or to its RAM row.
    if (pos_wr && pos_root_q) begin
      root_d = pos_val;
    end
  end

  // Row image with the current slot replaced.
  always_comb begin
    wr_row             = cur_row_q;
    wr_row[pos_lane_q] = pos_val;
  end

  assign ram_we    = pos_wr && !pos_root_q;
  assign ram_waddr = pos_row_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smh_pkg::S_IDLE;
      count_q     <= '0;
      cap_q       <= smh_pkg::CAP_RESET;
      root_q      <= smh_pkg::KEY_FREE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    cur_row_q    <= cur_row_d;
    par_row_q    <= par_row_d;
    par_m1_q     <= par_m1_d;
    pos_row_q    <= pos_row_d;
    pos_lane_q   <= pos_lane_d;
    pos_node_q   <= pos_node_d;
    pos_root_q   <= pos_root_d;
    nvalid_q     <= nvalid_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    for (int g = 0; g < G; g++) begin
      grp_val_q[g] <= grp_val_c[g];
      grp_idx_q[g] <= grp_idx_c[g];
    end
  end

  // Ports.
  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == smh_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign popped_key_o = out_key_q;

`ifndef SYNTH
  // The key count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_KEYS)
    else $error("key count beyond store depth");

  // A read and a write in the same cycle never touch the same row.
  a_no_row_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same row");

  // An accepted pop on a non-empty heap removes exactly one key.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == smh_pkg::CMD_POP) && (count_q != '0))
    |=> (count_q == $past(count_q) - CW'(1)))
    else $error("pop did not decrement the key count");

  // A refused push leaves the key count alone.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == smh_pkg::CMD_PUSH) && full)
    |=> $stable(count_q))
    else $error("refused push changed the key count");

  // A finished transaction reaches the output register once it is free.
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == smh_pkg::S_FIN) && (!out_valid_o || out_ready_i)) |=> out_valid_o)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
